FILE: hdl/pcfb_pkg.sv
// shared types, constants and the crc-8 byte update for the peci frame builder
// no dependencies; compiled first
package pcfb_pkg;

  localparam int FIFO_BYTES_DEF = 32;
  localparam int MAX_WRITE_LEN  = 28;
  localparam int HDR_BYTES      = 4;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] FCS_XOR  = 8'h80;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef logic [7:0] byte_t;
  typedef logic [4:0] len_t;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    REG_PING     = 2'd0,
    REG_GET_DIB  = 2'd1,
    REG_GET_TEMP = 2'd2,
    REG_WR_PKG   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    byte_t ping_code;
    byte_t get_dib_code;
    byte_t get_temp_code;
    byte_t wr_pkg_cfg_code;
  } cfg_t;

  typedef struct packed {
    byte_t frame_byte;
    logic  last_byte;
    logic  check_cc;
    logic  retry_allowed;
  } out_t;

  // msb-first crc-8, one byte
  function automatic byte_t crc_byte(input byte_t crc, input byte_t b);
    byte_t c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: hdl/pcfb_in_if.sv
// input channel of the peci frame builder: header and payload items
// depends on pcfb_pkg
interface pcfb_in_if;
  import pcfb_pkg::*;

  logic  valid;
  logic  ready;
  logic  kind;
  byte_t target_address;
  byte_t command_code;
  len_t  write_length;
  len_t  resp_length;
  byte_t payload_byte;

  modport source (
    output valid, kind, target_address, command_code, write_length, resp_length,
           payload_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, target_address, command_code, write_length, resp_length,
           payload_byte,
    output ready
  );
endinterface

FILE: hdl/pcfb_out_if.sv
// output channel of the peci frame builder: one frame byte per transaction
// depends on pcfb_pkg
interface pcfb_out_if;
  import pcfb_pkg::*;

  logic  valid;
  logic  ready;
  byte_t frame_byte;
  logic  last_byte;
  logic  check_cc;
  logic  retry_allowed;

  modport source (
    output valid, frame_byte, last_byte, check_cc, retry_allowed,
    input  ready
  );
  modport sink (
    input  valid, frame_byte, last_byte, check_cc, retry_allowed,
    output ready
  );
endinterface

FILE: hdl/pcfb_cfg_regs.sv
// apb-style register file holding the four command codes
// depends on pcfb_pkg
module pcfb_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pcfb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pcfb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pcfb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output pcfb_pkg::cfg_t                  cfg
);
  import pcfb_pkg::*;

  reg_idx_t idx;
  logic     wr;
  byte_t    rd_byte;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ping_code       <= 8'd0;
      cfg.get_dib_code    <= 8'd247;
      cfg.get_temp_code   <= 8'd1;
      cfg.wr_pkg_cfg_code <= 8'd165;
    end else if (wr) begin
      unique case (idx)
        REG_PING:     cfg.ping_code       <= pwdata[7:0];
        REG_GET_DIB:  cfg.get_dib_code    <= pwdata[7:0];
        REG_GET_TEMP: cfg.get_temp_code   <= pwdata[7:0];
        REG_WR_PKG:   cfg.wr_pkg_cfg_code <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PING:     rd_byte = cfg.ping_code;
      REG_GET_DIB:  rd_byte = cfg.get_dib_code;
      REG_GET_TEMP: rd_byte = cfg.get_temp_code;
      REG_WR_PKG:   rd_byte = cfg.wr_pkg_cfg_code;
    endcase
  end

  assign prdata = {{(APB_DATA_W-8){1'b0}}, rd_byte};
endmodule

FILE: hdl/pcfb_emitter.sv
// input register and byte sequencer: turns header and payload items into frame bytes
// and keeps the running crc and payload count; depends on pcfb_pkg, pcfb_in_if
module pcfb_emitter #(
  parameter int FIFO_BYTES = pcfb_pkg::FIFO_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  pcfb_pkg::cfg_t cfg,
  pcfb_in_if.sink        in_ch,
  output logic           push_valid,
  output pcfb_pkg::out_t push_data,
  input  logic           push_ready
);
  import pcfb_pkg::*;

  localparam int WMAX = ((FIFO_BYTES - HDR_BYTES) < MAX_WRITE_LEN) ?
                        (FIFO_BYTES - HDR_BYTES) : MAX_WRITE_LEN;
  localparam len_t WMAX_L = len_t'(WMAX);

  typedef struct packed {
    logic  kind;
    byte_t addr;
    byte_t cmd;
    len_t  wl;
    len_t  rl;
    byte_t pay;
  } item_t;

  // held item and sequencer state
  logic  work_valid;
  item_t work;
  len_t  k;
  byte_t running_crc;
  len_t  payload_remaining;
  logic  assured_write_mode;
  logic  general_command_mode;

  logic       accept;
  logic       is_hdr;
  logic       is_ping, special, aw;
  logic [5:0] total, n;
  logic       hdr_last, hdr_final;
  byte_t      hdr_raw, hdr_b;
  byte_t      crc_base;
  logic       pay_active, pl_last;
  len_t       rem_dec;
  byte_t      pl_b;
  byte_t      emit_b;
  logic       emit_ok, item_done;

  assign is_hdr  = (work.kind == KIND_HEADER);
  assign is_ping = (work.cmd == cfg.ping_code);
  assign special = is_ping || (work.cmd == cfg.get_dib_code) ||
                   (work.cmd == cfg.get_temp_code);
  assign aw      = (work.cmd == cfg.wr_pkg_cfg_code);

  assign total    = {1'b0, work.wl} + 6'(HDR_BYTES);
  assign n        = special ? total : 6'(HDR_BYTES);
  assign hdr_last = ({1'b0, k} == total - 6'd1);
  assign hdr_final = ({1'b0, k} == n - 6'd1);

  always_comb begin
    unique case (k)
      5'd0:    hdr_raw = work.addr;
      5'd1:    hdr_raw = {3'b000, work.wl} + 8'd1;
      5'd2:    hdr_raw = {3'b000, work.rl};
      5'd3:    hdr_raw = is_ping ? 8'd0 : work.cmd;
      default: hdr_raw = 8'd0;
    endcase
  end

  // a header frame restarts the crc at its first byte
  assign crc_base = (is_hdr && (k == 5'd0)) ? 8'd0 : running_crc;
  assign hdr_b    = (hdr_last && aw) ? (crc_base ^ FCS_XOR) : hdr_raw;

  assign pay_active = (payload_remaining != 5'd0);
  assign rem_dec    = payload_remaining - 5'd1;
  assign pl_last    = (rem_dec == 5'd0);
  assign pl_b       = (pl_last && assured_write_mode) ? (running_crc ^ FCS_XOR) : work.pay;

  assign emit_b     = is_hdr ? hdr_b : pl_b;
  assign push_valid = work_valid && (is_hdr || pay_active);
  assign emit_ok    = push_valid && push_ready;

  assign push_data.frame_byte    = emit_b;
  assign push_data.last_byte     = is_hdr ? hdr_last : pl_last;
  assign push_data.check_cc      = is_hdr ? !special : general_command_mode;
  assign push_data.retry_allowed = is_hdr ? !special : general_command_mode;

  // a stray payload item finishes without a byte
  assign item_done = work_valid &&
                     (is_hdr ? (emit_ok && hdr_final) : (!pay_active || emit_ok));

  assign in_ch.ready = !work_valid || item_done;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid           <= 1'b0;
      running_crc          <= 8'd0;
      payload_remaining    <= 5'd0;
      assured_write_mode   <= 1'b0;
      general_command_mode <= 1'b0;
      k                    <= 5'd0;
    end else begin
      if (emit_ok) begin
        running_crc <= crc_byte(crc_base, emit_b);
        if (is_hdr) begin
          if (!accept) k <= k + 5'd1;
          if (hdr_final) begin
            if (special || (work.wl == 5'd0)) begin
              payload_remaining    <= 5'd0;
              assured_write_mode   <= 1'b0;
              general_command_mode <= 1'b0;
            end else begin
              payload_remaining    <= work.wl;
              assured_write_mode   <= aw;
              general_command_mode <= 1'b1;
            end
          end
        end else begin
          payload_remaining <= rem_dec;
          if (pl_last) begin
            assured_write_mode   <= 1'b0;
            general_command_mode <= 1'b0;
          end
        end
      end
      if (accept) begin
        work_valid <= 1'b1;
        k          <= 5'd0;
      end else if (item_done) begin
        work_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work.kind <= in_ch.kind;
      work.addr <= in_ch.target_address;
      work.cmd  <= in_ch.command_code;
      work.wl   <= (in_ch.write_length > WMAX_L) ? WMAX_L : in_ch.write_length;
      work.rl   <= in_ch.resp_length;
      work.pay  <= in_ch.payload_byte;
    end
  end
endmodule

FILE: hdl/pcfb_out_skid.sv
// output register with a skid stage between the sequencer and the output channel
// depends on pcfb_pkg, pcfb_out_if
module pcfb_out_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  pcfb_pkg::out_t push_data,
  output logic           push_ready,
  pcfb_out_if.source     out_ch
);
  import pcfb_pkg::*;

  logic out_valid;
  out_t out_data;
  logic skid_valid;
  out_t skid_data;
  logic push, pop;

  assign push_ready = !skid_valid;
  assign push       = push_valid && push_ready;
  assign pop        = out_valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.frame_byte    = out_data.frame_byte;
  assign out_ch.last_byte     = out_data.last_byte;
  assign out_ch.check_cc      = out_data.check_cc;
  assign out_ch.retry_allowed = out_data.retry_allowed;
endmodule

FILE: hdl/peci_command_frame_builder.sv
// peci command frame builder: config registers, byte sequencer, output skid
// depends on pcfb_pkg, pcfb_in_if, pcfb_out_if, pcfb_cfg_regs, pcfb_emitter, pcfb_out_skid
//
// usage
//   in_ch takes header items (kind 0) and payload items (kind 1); out_ch gives one
//   frame byte per transaction with last_byte on the final byte of each frame.
//   the four command codes sit behind a small apb port at byte addresses 0, 4, 8, 12.
// throughput
//   the sequencer emits one frame byte per cycle while out_ch is not stalled.
//   a payload item emits one byte, an ordinary header 4 bytes, a ping, GetDIB
//   or GetTemp header write_length + 4 bytes, with write_length clamped to WMAX.
//   a stray payload item emits nothing.
// data path
//   an item is registered in work; each byte reaches out_ch via the output register.
// reset
//   rst is synchronous; it clears the held item, crc and payload count and loads the
//   default command codes.
// stall
//   while out_ch is stalled one more byte lands in the skid stage, then in_ch.ready
//   drops once the held item cannot progress; nothing is lost or repeated.
module peci_command_frame_builder #(
  parameter int FIFO_BYTES = pcfb_pkg::FIFO_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pcfb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pcfb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pcfb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  pcfb_in_if.sink                         in_ch,
  pcfb_out_if.source                      out_ch
);
  import pcfb_pkg::*;

  cfg_t cfg;
  logic push_valid;
  out_t push_data;
  logic push_ready;

  pcfb_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcfb_emitter #(
    .FIFO_BYTES (FIFO_BYTES)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  pcfb_out_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );
endmodule

FILE: hdl/pcfb_checker.sv
// port-level checks of the peci frame builder, bound to the top level
// depends on pcfb_pkg and peci_command_frame_builder
module pcfb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [pcfb_pkg::APB_ADDR_W-1:0] paddr,
  input logic [pcfb_pkg::APB_DATA_W-1:0] pwdata,
  input logic [pcfb_pkg::APB_DATA_W-1:0] prdata,
  input logic                            pready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [7:0]                      out_byte,
  input logic                            out_check,
  input logic                            out_retry
);
  import pcfb_pkg::*;

  logic wr;
  assign wr = psel && penable && pwrite && pready;

  // a stalled output transaction stays valid and keeps its frame byte
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("output transaction changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_check == out_retry)
    else $error("check_cc and retry_allowed differ");

  // a register read right after a write returns the written code
  a_readback: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(wr) && psel && !pwrite && paddr == $past(paddr)
      |-> prdata == {{(APB_DATA_W-8){1'b0}}, $past(pwdata[7:0])})
    else $error("register readback mismatch");
endmodule

bind peci_command_frame_builder pcfb_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.frame_byte),
  .out_check (out_ch.check_cc),
  .out_retry (out_ch.retry_allowed)
);
